### src/pcomp_pkg.sv
// pcomp_pkg: shared types, constants and arithmetic helpers for the palette compositor
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package pcomp_pkg;

   // item kinds carried in the first tuser bit
   localparam logic MODE_LOAD      = 1'b0;
   localparam logic MODE_COMPOSITE = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
   localparam logic [15:0] ROUND_HALF  = 16'd127;

   // one classified item between front and back
   typedef struct packed {
      logic       is_comp;
      logic       store_only;
      logic [7:0] slot;
      logic [7:0] blue;    // premultiplied on load, destination on composite
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } queue_entry_type;

   // exact x / 255 for any 16-bit x up to 65279
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

   function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
      logic [15:0] p;
      p = 16'(c) * 16'(a) + ROUND_HALF;
      return div255(p);
   endfunction

   function automatic logic [7:0] over(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] inv);
      logic [15:0] p;
      p = 16'(d) * 16'(inv) + ROUND_HALF;
      return s + div255(p);
   endfunction

endpackage

### src/pcomp_front.sv
// pcomp_front: classifies input items, folds the index into the palette and premultiplies loads
// depends on pcomp_pkg
`timescale 1ns / 1ps

module pcomp_front
   import pcomp_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic [39:0]     req_tdata,
   input  logic [1:0]      req_tuser,
   output queue_entry_type entry
);

   localparam int FOLD_BITS = 8 * 256;

   // index modulo depth for every possible 8-bit index, built at elaboration
   function automatic logic [FOLD_BITS-1:0] build_fold();
      logic [FOLD_BITS-1:0] t;
      t = '0;
      for (int k = 0; k < 256; k++) begin
         t[k*8 +: 8] = 8'(k % PALETTE_DEPTH);
      end
      return t;
   endfunction

   localparam logic [FOLD_BITS-1:0] FOLD_TABLE = build_fold();

   logic [7:0] idx;
   logic [7:0] c_blue;
   logic [7:0] c_green;
   logic [7:0] c_red;
   logic [7:0] c_alpha;
   logic       is_comp;

   assign idx     = req_tdata[7:0];
   assign c_blue  = req_tdata[15:8];
   assign c_green = req_tdata[23:16];
   assign c_red   = req_tdata[31:24];
   assign c_alpha = req_tdata[39:32];
   assign is_comp = (req_tuser[0] == MODE_COMPOSITE);

   always_comb begin
      entry.is_comp    = is_comp;
      entry.store_only = req_tuser[1];
      entry.slot       = FOLD_TABLE[{idx, 3'b000} +: 8];
      entry.alpha      = c_alpha;
      if (is_comp) begin
         entry.blue  = c_blue;
         entry.green = c_green;
         entry.red   = c_red;
      end else begin
         entry.blue  = premul(c_blue, c_alpha);
         entry.green = premul(c_green, c_alpha);
         entry.red   = premul(c_red, c_alpha);
      end
   end

endmodule

### src/pcomp_queue.sv
// pcomp_queue: short first-in first-out queue of classified items
// depends on pcomp_pkg
`timescale 1ns / 1ps

module pcomp_queue
   import pcomp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output queue_entry_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type slots_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/pcomp_back.sv
// pcomp_back: palette memory, source-over blend and result register
// depends on pcomp_pkg
`timescale 1ns / 1ps

module pcomp_back
   import pcomp_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   input  queue_entry_type q_head,
   output logic            q_pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [31:0]     rsp_tdata,
   output logic            rsp_tuser
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [31:0] mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] entry_ok_ff;
   logic [AW-1:0] addr;

   logic        out_can;
   logic        s2_adv;
   logic        pop_load;
   logic        pop_comp;

   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] rd_ff;
   logic        s2_ok_ff;
   logic        s2_store_ff;
   logic [7:0]  s2_blue_ff, s2_green_ff, s2_red_ff, s2_alpha_ff;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;
   logic        out_vis_ff, out_vis_in;

   logic [31:0] src;
   logic [7:0]  sb, sg, sr, sa, inv;

   assign addr     = q_head.slot[AW-1:0];
   assign out_can  = !out_valid_ff || rsp_tready;
   assign s2_adv   = !s2_valid_ff || out_can;
   // loads retire at the memory; composites need room in the read stage
   assign q_pop    = q_not_empty && (!q_head.is_comp || s2_adv);
   assign pop_load = q_pop && !q_head.is_comp;
   assign pop_comp = q_pop && q_head.is_comp;

   always_comb begin
      if (pop_comp) begin
         s2_valid_in = 1'b1;
      end else if (out_can) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ok_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (pop_load) begin
            entry_ok_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_load) begin
         mem[addr] <= {q_head.alpha, q_head.red, q_head.green, q_head.blue};
      end
      if (pop_comp) begin
         rd_ff       <= mem[addr];
         s2_ok_ff    <= entry_ok_ff[addr];
         s2_store_ff <= q_head.store_only;
         s2_blue_ff  <= q_head.blue;
         s2_green_ff <= q_head.green;
         s2_red_ff   <= q_head.red;
         s2_alpha_ff <= q_head.alpha;
      end
   end

   // never-loaded entries read as transparent black
   assign src = s2_ok_ff ? rd_ff : 32'd0;
   assign sb  = src[7:0];
   assign sg  = src[15:8];
   assign sr  = src[23:16];
   assign sa  = src[31:24];
   assign inv = ALPHA_OPAQUE - sa;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_vis_in   = out_vis_ff;
      if (out_can) begin
         out_valid_in = s2_valid_ff;
         out_vis_in   = (sa != ALPHA_CLEAR);
         if (s2_store_ff) begin
            out_data_in = src;
         end else if (sa == ALPHA_CLEAR) begin
            out_data_in = {s2_alpha_ff, s2_red_ff, s2_green_ff, s2_blue_ff};
         end else if (sa == ALPHA_OPAQUE) begin
            out_data_in = {ALPHA_OPAQUE, sr, sg, sb};
         end else begin
            out_data_in = {over(sa, s2_alpha_ff, inv), over(sr, s2_red_ff, inv),
                           over(sg, s2_green_ff, inv), over(sb, s2_blue_ff, inv)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_vis_ff  <= out_vis_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_vis_ff;

endmodule

### src/palette_premultiplied_compositor_core.sv
// palette_premultiplied_compositor_core: top level of the premultiplied palette compositor
// depends on pcomp_pkg, pcomp_front, pcomp_queue, pcomp_back
//
//   channel | ports      | carries
//   --------+------------+---------------------------------------------------
//   request | req_t*     | load palette entry or composite one pixel
//   response| rsp_t*     | one blended or copied pixel per composite item
//
// one item per clock sustained while the response is accepted; a composite result passes
// through the queue slot, the palette read register and the blend register to rsp_t*,
// a load finishes at the palette write. reset clears the queue, the pipeline and the
// per-entry valid bits at once, so the palette reads as transparent right away. a
// stalled response holds the result register; the four-entry queue keeps taking items until full
`timescale 1ns / 1ps

module palette_premultiplied_compositor_core
   import pcomp_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // palette_index, chan_blue, chan_green, chan_red, chan_alpha
   input  logic [1:0]  req_tuser,   // mode, store_only
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_blue, out_green, out_red, out_alpha
   output logic        rsp_tuser    // source_visible
);

   queue_entry_type front_entry;
   queue_entry_type q_head;
   logic            q_full;
   logic            q_not_empty;
   logic            q_pop;
   logic            push;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   pcomp_front #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_front (
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .entry    (front_entry)
   );

   pcomp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   pcomp_back #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sim/palette_premultiplied_compositor_core_tb.sv
// palette_premultiplied_compositor_core_tb: self-checking bench for the palette compositor
// drives a directed table then random load/composite items with random idling on both sides
// depends on pcomp_pkg and palette_premultiplied_compositor_core
`timescale 1ns / 1ps

module palette_premultiplied_compositor_core_tb;
   import pcomp_pkg::*;

   localparam int PALETTE_DEPTH = 256;
   localparam int RANDOM_ITEMS  = 1880;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 12;
   localparam logic TYPED       = 1'b1;
   localparam logic PREDICTED   = 1'b0;

   typedef struct packed {
      logic       mode;
      logic       store_only;
      logic [7:0] index;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       visible;
   } pixel_out_type;

   typedef struct packed {
      pixel_req_type req;
      logic          typed;
      pixel_out_type want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // palette_index, chan_blue, chan_green, chan_red, chan_alpha
   logic [1:0]  req_tuser;   // mode, store_only
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // out_blue, out_green, out_red, out_alpha
   logic        rsp_tuser;   // source_visible

   logic [31:0]   palette_mem [PALETTE_DEPTH];
   pixel_out_type pixel_expect [$];
   table_row_type stim_table [$];
   int            hot_slots [$];
   int            fail_count = 0;
   int            cycle_count = 0;
   logic          steady = 1'b0;
   pixel_out_type want_px;

   palette_premultiplied_compositor_core #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounded c*k/255, used both for premultiply and for the blend term
   function automatic logic [7:0] scale_round(input logic [7:0] c, input logic [7:0] k);
      int unsigned p;
      p = int'(c) * int'(k) + 127;
      return 8'(p / 255);
   endfunction

   // updates the palette copy; returns 1 with the pixel when the item gives a result
   function automatic logic predict_pixel(input pixel_req_type rq, output pixel_out_type px);
      int         slot;
      logic [7:0] sb, sg, sr, sa, inv;
      slot = int'(rq.index) % PALETTE_DEPTH;
      px = '0;
      if (rq.mode == MODE_LOAD) begin
         palette_mem[slot] = {rq.alpha, scale_round(rq.red, rq.alpha),
                              scale_round(rq.green, rq.alpha), scale_round(rq.blue, rq.alpha)};
         return 1'b0;
      end
      {sa, sr, sg, sb} = palette_mem[slot];
      px.visible = (sa != ALPHA_CLEAR);
      if (rq.store_only) begin
         {px.alpha, px.red, px.green, px.blue} = {sa, sr, sg, sb};
      end else if (sa == ALPHA_CLEAR) begin
         {px.alpha, px.red, px.green, px.blue} = {rq.alpha, rq.red, rq.green, rq.blue};
      end else if (sa == ALPHA_OPAQUE) begin
         {px.alpha, px.red, px.green, px.blue} = {ALPHA_OPAQUE, sr, sg, sb};
      end else begin
         inv = ALPHA_OPAQUE - sa;
         px.blue  = sb + scale_round(rq.blue, inv);
         px.green = sg + scale_round(rq.green, inv);
         px.red   = sr + scale_round(rq.red, inv);
         px.alpha = sa + scale_round(rq.alpha, inv);
      end
      return 1'b1;
   endfunction

   function automatic table_row_type row(input logic mode, input logic store_only,
                                         input logic [7:0] index, input logic [7:0] blue,
                                         input logic [7:0] green, input logic [7:0] red,
                                         input logic [7:0] alpha, input logic typed,
                                         input pixel_out_type want);
      table_row_type r;
      r.req = {mode, store_only, index, blue, green, red, alpha};
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   // composites mostly hit recently loaded entries so blends see real colors
   function automatic pixel_req_type random_item();
      pixel_req_type rq;
      int            pick;
      rq.mode = ($urandom_range(99) < 35) ? MODE_LOAD : MODE_COMPOSITE;
      rq.store_only = ($urandom_range(99) < 25);
      if (hot_slots.size() > 0 && $urandom_range(99) < 70) begin
         rq.index = 8'(hot_slots[$urandom_range(hot_slots.size() - 1)]);
      end else begin
         rq.index = 8'($urandom_range(255));
      end
      rq.blue  = 8'($urandom_range(255));
      rq.green = 8'($urandom_range(255));
      rq.red   = 8'($urandom_range(255));
      pick = $urandom_range(9);
      rq.alpha = (pick == 0) ? ALPHA_CLEAR : (pick == 1) ? ALPHA_OPAQUE : 8'($urandom_range(255));
      if (rq.mode == MODE_LOAD) begin
         hot_slots.insert(hot_slots.size(), int'(rq.index));
         if (hot_slots.size() > 8) void'(hot_slots.pop_front());
      end
      return rq;
   endfunction

   // entered and left at a falling edge; valid stays high into the next item
   task automatic drive_item(input pixel_req_type rq, input logic typed,
                             input pixel_out_type want);
      pixel_out_type px;
      while (!steady && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rq.alpha, rq.red, rq.green, rq.blue, rq.index};
      req_tuser  <= {rq.store_only, rq.mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_pixel(rq, px)) pixel_expect.insert(pixel_expect.size(), typed ? want : px);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %02h got %02h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 9);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout", $time);
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_expect.size() == 0) begin
            $display("%0t ns: pixel expected none got %08h/%0b", $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want_px = pixel_expect.pop_front();
            check_field("out_blue", want_px.blue, rsp_tdata[7:0]);
            check_field("out_green", want_px.green, rsp_tdata[15:8]);
            check_field("out_red", want_px.red, rsp_tdata[23:16]);
            check_field("out_alpha", want_px.alpha, rsp_tdata[31:24]);
            check_field("source_visible", 8'(want_px.visible), 8'(rsp_tuser));
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      for (int i = 0; i < PALETTE_DEPTH; i++) palette_mem[i] = '0;

      // palette is transparent after reset: destination passes, copy gives zeros
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h00, 8'h11, 8'h22,
                        8'h33, 8'h44, TYPED, {8'h11, 8'h22, 8'h33, 8'h44, 1'b0}));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b1, 8'hff, 8'hff, 8'hff,
                        8'hff, 8'hff, TYPED, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}));
      // opaque load keeps colors; store flag on a load is ignored
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b1, 8'h00, 8'h12, 8'h34, 8'h56,
                        8'hff, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b1, 8'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, TYPED, {8'h12, 8'h34, 8'h56, 8'hff, 1'b1}));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h00, 8'haa, 8'hbb,
                        8'hcc, 8'hdd, TYPED, {8'h12, 8'h34, 8'h56, 8'hff, 1'b1}));
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff,
                        8'hff, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'hff, 8'h00, 8'h00,
                        8'h00, 8'h00, TYPED, {8'hff, 8'hff, 8'hff, 8'hff, 1'b1}));
      // zero alpha load wipes the colors
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff,
                        8'h00, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b1, 8'hff, 8'h5a, 8'ha5,
                        8'h5a, 8'ha5, TYPED, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'hff, 8'h80, 8'h81,
                        8'h82, 8'h83, TYPED, {8'h80, 8'h81, 8'h82, 8'h83, 1'b0}));
      // partial alpha: premultiply and blend
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b0, 8'h80, 8'hff, 8'h80, 8'h00,
                        8'h80, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b1, 8'h80, 8'h00, 8'h00,
                        8'h00, 8'h00, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h80, 8'hff, 8'hff,
                        8'hff, 8'hff, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h80, 8'h00, 8'h00,
                        8'h00, 8'h00, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b0, 8'h01, 8'hff, 8'hff, 8'hff,
                        8'h01, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h01, 8'hff, 8'hff,
                        8'hff, 8'hff, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b0, 8'h02, 8'hff, 8'hff, 8'hff,
                        8'hfe, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h02, 8'hff, 8'hff,
                        8'hff, 8'h00, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b1, 8'h02, 8'h3c, 8'hc3,
                        8'h3c, 8'hc3, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_LOAD, 1'b0, 8'h03, 8'h00, 8'h00, 8'h00,
                        8'h80, PREDICTED, '0));
      stim_table.insert(stim_table.size(), row(MODE_COMPOSITE, 1'b0, 8'h03, 8'hff, 8'h00,
                        8'hff, 8'h00, PREDICTED, '0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) drive_item(stim_table[i].req, stim_table[i].typed,
                                         stim_table[i].want);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a long run with no idling on either side
         steady = (i >= 700 && i < 1000);
         drive_item(random_item(), PREDICTED, '0);
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (pixel_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
src/pcomp_pkg.sv
src/pcomp_front.sv
src/pcomp_queue.sv
src/pcomp_back.sv
src/palette_premultiplied_compositor_core.sv
sim/palette_premultiplied_compositor_core_tb.sv
